### sv/u16u8_pkg.sv
// u16u8_pkg: shared types, constants and UTF-8 encode helpers for the
// UTF-16 to UTF-8 transcoder. No dependencies.
`timescale 1ns / 1ps

package u16u8_pkg;

    localparam int CP_W   = 21;   // widest code point (up to 0x10FFFF)
    localparam int UNIT_W = 16;

    // Upper six bits of a surrogate code unit
    localparam logic [5:0] HIGH_TAG = 6'b110110;
    localparam logic [5:0] LOW_TAG  = 6'b110111;

    localparam logic [CP_W-1:0] SUPP_BASE = 21'h10000;

    // UTF-8 lead and continuation prefixes
    localparam logic [2:0] LEAD2_TAG = 3'b110;
    localparam logic [3:0] LEAD3_TAG = 4'b1110;
    localparam logic [4:0] LEAD4_TAG = 5'b11110;
    localparam logic [1:0] CONT_TAG  = 2'b10;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        final_unit;
    } unit_t;

    typedef struct packed {
        logic [7:0] utf8_byte;
        logic       run_end;
        logic       string_end;
    } byte_t;

    // One queued job: an optional leading code point (held surrogate or
    // joined pair) followed by an optional plain code unit.
    typedef struct packed {
        logic              seg_a_en;
        logic [CP_W-1:0]   seg_a_cp;
        logic              seg_b_en;
        logic [UNIT_W-1:0] seg_b_cp;
        logic              last;
    } entry_t;

    function automatic logic [2:0] enc_len(input logic [CP_W-1:0] cp);
        logic [2:0] len;
        if (cp < 21'h80)
            len = 3'd1;
        else if (cp < 21'h800)
            len = 3'd2;
        else if (cp < SUPP_BASE)
            len = 3'd3;
        else
            len = 3'd4;
        return len;
    endfunction

    function automatic logic [7:0] enc_byte(input logic [CP_W-1:0] cp,
                                            input logic [2:0]      len,
                                            input logic [1:0]      k);
        logic [7:0] b;
        b = {CONT_TAG, cp[5:0]};
        unique case (len)
            3'd1: b = cp[7:0];
            3'd2:
            begin
                if (k == 2'd0)
                    b = {LEAD2_TAG, cp[10:6]};
            end
            3'd3:
            begin
                case (k)
                    2'd0:    b = {LEAD3_TAG, cp[15:12]};
                    2'd1:    b = {CONT_TAG, cp[11:6]};
                    default: b = {CONT_TAG, cp[5:0]};
                endcase
            end
            default:
            begin
                case (k)
                    2'd0:    b = {LEAD4_TAG, cp[20:18]};
                    2'd1:    b = {CONT_TAG, cp[17:12]};
                    2'd2:    b = {CONT_TAG, cp[11:6]};
                    default: b = {CONT_TAG, cp[5:0]};
                endcase
            end
        endcase
        return b;
    endfunction

endpackage

### sv/u16u8_front.sv
// u16u8_front: accepts code units, holds a pending high surrogate and turns
// each transfer that yields output into a queue job. Depends on u16u8_pkg.
`timescale 1ns / 1ps

module u16u8_front
    import u16u8_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   unit_valid,
    output logic   unit_stall,
    input  unit_t  unit_data,
    output logic   push,
    output entry_t push_data,
    input  logic   full
);

    logic       pend_valid_reg, pend_valid_next;
    logic [9:0] pend_bits_reg, pend_bits_next;

    logic       accept;
    logic       is_high, is_low, hold_new;
    entry_t     entry;

    assign is_high  = unit_data.code_unit[15:10] == HIGH_TAG;
    assign is_low   = unit_data.code_unit[15:10] == LOW_TAG;
    assign hold_new = is_high && !unit_data.final_unit;

    assign unit_stall = full;
    assign accept     = unit_valid && !full;

    always_comb
    begin
        entry.seg_a_en = pend_valid_reg;
        if (is_low)
            entry.seg_a_cp = SUPP_BASE + {1'b0, pend_bits_reg, unit_data.code_unit[9:0]};
        else
            entry.seg_a_cp = {5'd0, HIGH_TAG, pend_bits_reg};
        // a joined pair consumes the unit; a non-final high surrogate gets held
        entry.seg_b_en = !hold_new && !(pend_valid_reg && is_low);
        entry.seg_b_cp = unit_data.code_unit;
        entry.last     = unit_data.final_unit;

        pend_valid_next = pend_valid_reg;
        pend_bits_next  = pend_bits_reg;
        if (accept)
        begin
            pend_valid_next = hold_new;
            if (hold_new)
                pend_bits_next = unit_data.code_unit[9:0];
        end
    end

    assign push      = accept && (entry.seg_a_en || entry.seg_b_en);
    assign push_data = entry;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            pend_bits_reg  <= '0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            pend_bits_reg  <= pend_bits_next;
        end
    end

`ifndef SYNTHESIS
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("front pushed into a full queue");

    a_final_clears_pending: assert property (@(posedge clk) disable iff (!rst_n)
        accept && unit_data.final_unit |=> !pend_valid_reg)
        else $error("surrogate still held after final unit");
`endif

endmodule

### sv/u16u8_queue.sv
// u16u8_queue: small FIFO of jobs between front and back.
// Depends on u16u8_pkg.
`timescale 1ns / 1ps

module u16u8_queue
    import u16u8_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_data,
    output logic   full,
    input  logic   pop,
    output entry_t pop_data,
    output logic   empty
);

    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(DEPTH);

    entry_t            mem_reg [DEPTH];
    logic [ADDR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [ADDR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign full     = count_reg == FULL_CNT;
    assign empty    = count_reg == '0;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST_ADDR) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST_ADDR) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push && full |-> pop)
        else $error("queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("queue underflow");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("queue count out of range");
`endif

endmodule

### sv/u16u8_back.sv
// u16u8_back: pulls jobs from the queue and sends their UTF-8 bytes one per
// cycle while byte_stall is low, through an output register. Depends on u16u8_pkg.
`timescale 1ns / 1ps

module u16u8_back
    import u16u8_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  entry_t q_data,
    input  logic   q_empty,
    output logic   q_pop,
    output logic   byte_valid,
    input  logic   byte_stall,
    output byte_t  byte_data
);

    entry_t     cur_reg, cur_next;
    logic       cur_valid_reg, cur_valid_next;
    logic       seg_reg, seg_next;          // 0: leading code point, 1: plain unit
    logic [1:0] idx_reg, idx_next;
    logic       out_valid_reg, out_valid_next;
    byte_t      out_reg, out_next;

    logic [CP_W-1:0] sel_cp;
    logic [2:0]      len;
    logic            load_ok, advance, seg_last, entry_last;

    assign sel_cp     = seg_reg ? {5'd0, cur_reg.seg_b_cp} : cur_reg.seg_a_cp;
    assign len        = enc_len(sel_cp);
    assign seg_last   = ({1'b0, idx_reg} + 3'd1) == len;
    assign entry_last = seg_last && (seg_reg || !cur_reg.seg_b_en);

    assign load_ok = !out_valid_reg || !byte_stall;
    assign advance = cur_valid_reg && load_ok;
    assign q_pop   = !q_empty && (!cur_valid_reg || (advance && entry_last));

    always_comb
    begin
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        seg_next       = seg_reg;
        idx_next       = idx_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;

        if (load_ok)
            out_valid_next = advance;

        if (advance)
        begin
            out_next.utf8_byte  = enc_byte(sel_cp, len, idx_reg);
            out_next.run_end    = entry_last;
            out_next.string_end = entry_last && cur_reg.last;
            if (entry_last)
                cur_valid_next = 1'b0;
            else if (seg_last)
            begin
                seg_next = 1'b1;
                idx_next = '0;
            end
            else
                idx_next = idx_reg + 2'd1;
        end

        if (q_pop)
        begin
            cur_next       = q_data;
            cur_valid_next = 1'b1;
            seg_next       = !q_data.seg_a_en;
            idx_next       = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            seg_reg       <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            seg_reg       <= seg_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign byte_valid = out_valid_reg;
    assign byte_data  = out_reg;

`ifndef SYNTHESIS
    a_string_end_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.string_end |-> out_reg.run_end)
        else $error("string end without run end");

    a_seg_enabled: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg |-> (seg_reg ? cur_reg.seg_b_en : cur_reg.seg_a_en))
        else $error("working on a disabled segment");

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg |-> ({1'b0, idx_reg} < len))
        else $error("byte index past end of sequence");

    a_job_ends_on_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        advance && entry_last |=> out_valid_reg && out_reg.run_end)
        else $error("job finished without run end byte");
`endif

endmodule

### sv/utf16_to_utf8_transcoder.sv
// A code unit's job is written into the queue, loaded into the back end's
// job register and sent through the output register, one byte per cycle on
// the single output port while byte_stall is low; 0 to 6 bytes per code unit.
// The job queue (QUEUE_DEPTH entries) lets input keep flowing while bytes drain.
// Reset (rst_n low, asynchronous): queue empty, no surrogate held, no output.
`timescale 1ns / 1ps

module utf16_to_utf8_transcoder
    import u16u8_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  unit_valid,
    output logic  unit_stall,
    input  unit_t unit_data,
    output logic  byte_valid,
    input  logic  byte_stall,
    output byte_t byte_data
);

    logic   push, full, pop, empty;
    entry_t push_data, pop_data;

    u16u8_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .unit_valid (unit_valid),
        .unit_stall (unit_stall),
        .unit_data  (unit_data),
        .push       (push),
        .push_data  (push_data),
        .full       (full)
    );

    u16u8_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    u16u8_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_data     (pop_data),
        .q_empty    (empty),
        .q_pop      (pop),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_data  (byte_data)
    );

endmodule
